// File: hw/rtl/jss_pkg.sv
// Package for the Jacobi stencil sweep: field widths, payload types,
// configuration register indexes and reset values.
// No dependencies; compiled before every other file of the block.
`default_nettype none

package jss_pkg;

  localparam int VAL_W   = 32;
  localparam int COEF_W  = 48;
  localparam int CHUNK_W = 24;
  localparam int ESUM_W  = 64;
  localparam int FRAC_W  = 48;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [VAL_W-1:0]        mag_t;
  typedef logic [COEF_W-1:0]       coef_t;
  typedef logic [ESUM_W-1:0]       esum_t;
  typedef logic [11:0]             row_idx_t;
  typedef logic [9:0]              col_idx_t;
  typedef logic [2:0]              cfg_idx_t;
  typedef logic [COEF_W-1:0]       cfg_data_t;

  localparam cfg_idx_t CFG_COLUMNS = 3'd0;
  localparam cfg_idx_t CFG_ROWS    = 3'd1;
  localparam cfg_idx_t CFG_COEF_EW = 3'd2;
  localparam cfg_idx_t CFG_COEF_NS = 3'd3;
  localparam cfg_idx_t CFG_COEF_F  = 3'd4;
  localparam cfg_idx_t CFG_AREA    = 3'd5;

  localparam logic [10:0] COLUMNS_RESET = 11'd1024;
  localparam logic [12:0] ROWS_RESET    = 13'd4096;

  localparam value_t VALUE_MAX = 32'sh7FFFFFFF;
  localparam value_t VALUE_MIN = 32'sh80000000;

endpackage

`default_nettype wire

// File: hw/rtl/jss_channels.sv
// Valid/ready channel interfaces of the Jacobi stencil sweep: grid input,
// result output and configuration writes.
// Depends on jss_pkg for the payload types.
`default_nettype none

interface jss_in_if;
  import jss_pkg::*;

  logic   valid;
  logic   ready;
  value_t old_value;
  value_t forcing;
  value_t exact;

  modport source (output valid, old_value, forcing, exact, input ready);
  modport sink   (input valid, old_value, forcing, exact, output ready);
endinterface

interface jss_out_if;
  import jss_pkg::*;

  logic     valid;
  logic     ready;
  row_idx_t out_row;
  col_idx_t out_col;
  value_t   new_value;
  mag_t     max_error;
  esum_t    error_sum;
  logic     last;

  modport source (output valid, out_row, out_col, new_value, max_error, error_sum, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, new_value, max_error, error_sum, last,
                  output ready);
endinterface

interface jss_cfg_if;
  import jss_pkg::*;

  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/jacobi_stencil_sweep.sv
// Top level of the Jacobi stencil sweep: line buffer memory, stencil window,
// shared multiplier sequencer, error accumulators and output register.
// Depends on jss_pkg and the channel interfaces in jss_channels.sv.
//
//   channel | direction | beat carries
//   in_ch   | in        | old_value, forcing, exact of one grid point
//   out_ch  | out       | out_row, out_col, new_value, max_error, error_sum, last
//   cfg_ch  | in        | index and data of one register write
//
// An interior point works through the single 33x25 multiplier, which forms twelve
// partial products in turn; a boundary point does not use the multiplier.
// Reset is synchronous and clears position, accumulators and configuration; the
// line buffer memory holds garbage until written and gets no clearing pass.
// A finished result waits in the output register while the next point is taken;
// the sequencer holds in its last step only while that register is still full.
`default_nettype none

module jacobi_stencil_sweep #(
  parameter int ROW_WIDTH = 1024,
  parameter int MAX_ROWS  = 4096
) (
  input  logic      clk,
  input  logic      rst_n,
  jss_in_if.sink    in_ch,
  jss_out_if.source out_ch,
  jss_cfg_if.sink   cfg_ch
);
  import jss_pkg::*;

  localparam int COL_W      = $clog2(ROW_WIDTH);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int NCOL_W     = $clog2(ROW_WIDTH + 1);
  localparam int NROW_W     = $clog2(MAX_ROWS + 1);
  localparam int WORD_W     = 4 * VAL_W;
  localparam int ACC_W      = ESUM_W + COEF_W + 1;
  localparam int Q_W        = ACC_W - FRAC_W;
  localparam int MA_W       = VAL_W + 1;
  localparam int MB_W       = CHUNK_W + 1;
  localparam int PROD_W     = MA_W + MB_W;
  localparam int STEN_STEPS = 6;
  localparam int SQR_STEPS  = 2;
  localparam int AREA_STEPS = 4;

  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_STEN, S_ROUND, S_SQR, S_AREA, S_DONE
  } state_t;

  typedef enum logic [1:0] {SH_0, SH_24, SH_32, SH_56} shift_t;

  state_t state_r;
  logic [2:0] step_r;

  logic [10:0] cfg_cols_r;
  logic [12:0] cfg_rows_r;
  coef_t coef_ew_r, coef_ns_r, coef_f_r, area_r;
  logic [NCOL_W-1:0] cols_c;
  logic [NROW_W-1:0] rows_c;

  logic [COL_W-1:0] col_cnt_r, pos_col, c_r, next_col;
  logic [ROW_W-1:0] row_cnt_r, pos_row, r_r, next_row;
  logic [ROW_W:0]   row_step, row_inc;
  logic [COL_W:0]   col_inc;
  logic col_wrap, end_of_row, interior, is_last;

  logic in_fire, cfg_fire, out_load;

  logic [WORD_W-1:0] mem [ROW_WIDTH];
  logic [WORD_W-1:0] rd_word_r;
  value_t a_c, t_c, f_c, e_c;
  value_t cur_r, fcur_r, ecur_r;
  value_t win_a1_r, win_a2_r, win_n_r, win_s_r, win_f_r, win_e_r;

  logic signed [MA_W-1:0] op_ew_r, op_ns_r, op_f_r;
  value_t op_e_r;

  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod_r;
  shift_t mul_sh, sh_r;
  logic   mul_go, pv_r;

  logic signed [ACC_W-1:0] acc_r, acc_nxt, addend, prod_ext;
  logic signed [Q_W-1:0]   q;
  logic signed [VAL_W:0]   diff;
  value_t nv, nv_r;
  mag_t   adiff, adiff_r, max_acc_r, max_new;
  esum_t  sq_r, contrib, esum_acc_r, esum_new;
  logic [ESUM_W:0] esum_sum;

  logic     out_valid_r, out_last_r;
  row_idx_t out_row_r;
  col_idx_t out_col_r;
  value_t   out_nv_r;
  mag_t     out_max_r;
  esum_t    out_esum_r;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign cfg_fire = cfg_ch.valid && cfg_ch.ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_row   = out_row_r;
  assign out_ch.out_col   = out_col_r;
  assign out_ch.new_value = out_nv_r;
  assign out_ch.max_error = out_max_r;
  assign out_ch.error_sum = out_esum_r;
  assign out_ch.last      = out_last_r;

  assign t_c = rd_word_r[4*VAL_W-1:3*VAL_W];
  assign a_c = rd_word_r[3*VAL_W-1:2*VAL_W];
  assign f_c = rd_word_r[2*VAL_W-1:VAL_W];
  assign e_c = rd_word_r[VAL_W-1:0];

  always_comb begin
    if (cfg_cols_r < 11'd3) begin
      cols_c = NCOL_W'(3);
    end else if (32'(cfg_cols_r) > 32'(ROW_WIDTH)) begin
      cols_c = NCOL_W'(ROW_WIDTH);
    end else begin
      cols_c = NCOL_W'(cfg_cols_r);
    end
    if (cfg_rows_r < 13'd3) begin
      rows_c = NROW_W'(3);
    end else if (32'(cfg_rows_r) > 32'(MAX_ROWS)) begin
      rows_c = NROW_W'(MAX_ROWS);
    end else begin
      rows_c = NROW_W'(cfg_rows_r);
    end
  end

  // Position of an arriving point, after any wrap left by a shrunk geometry.
  always_comb begin
    col_wrap = 32'(col_cnt_r) >= 32'(cols_c);
    row_step = {1'b0, row_cnt_r} + {{ROW_W{1'b0}}, col_wrap};
    pos_col  = col_wrap ? '0 : col_cnt_r;
    pos_row  = (32'(row_step) >= 32'(rows_c)) ? '0 : row_step[ROW_W-1:0];
  end

  always_comb begin
    col_inc    = {1'b0, c_r} + {{COL_W{1'b0}}, 1'b1};
    row_inc    = {1'b0, r_r} + {{ROW_W{1'b0}}, 1'b1};
    end_of_row = 32'(col_inc) >= 32'(cols_c);
    next_col   = end_of_row ? '0 : col_inc[COL_W-1:0];
    if (!end_of_row) begin
      next_row = r_r;
    end else if (32'(row_inc) >= 32'(rows_c)) begin
      next_row = '0;
    end else begin
      next_row = row_inc[ROW_W-1:0];
    end
    interior = (32'(r_r) >= 32'd2) && (32'(c_r) >= 32'd2);
    is_last  = (32'(row_inc) == 32'(rows_c)) && (32'(col_inc) == 32'(cols_c));
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_sh = SH_0;
    mul_go = 1'b0;
    case (state_r)
      S_STEN: begin
        mul_go = step_r < 3'(STEN_STEPS);
        case (step_r)
          3'd0: begin
            mul_a = op_ew_r;
            mul_b = {1'b0, coef_ew_r[CHUNK_W-1:0]};
          end
          3'd1: begin
            mul_a  = op_ew_r;
            mul_b  = {1'b0, coef_ew_r[COEF_W-1:CHUNK_W]};
            mul_sh = SH_24;
          end
          3'd2: begin
            mul_a = op_ns_r;
            mul_b = {1'b0, coef_ns_r[CHUNK_W-1:0]};
          end
          3'd3: begin
            mul_a  = op_ns_r;
            mul_b  = {1'b0, coef_ns_r[COEF_W-1:CHUNK_W]};
            mul_sh = SH_24;
          end
          3'd4: begin
            mul_a = op_f_r;
            mul_b = {1'b0, coef_f_r[CHUNK_W-1:0]};
          end
          default: begin
            mul_a  = op_f_r;
            mul_b  = {1'b0, coef_f_r[COEF_W-1:CHUNK_W]};
            mul_sh = SH_24;
          end
        endcase
      end
      S_SQR: begin
        mul_go = step_r < 3'(SQR_STEPS);
        mul_a  = {1'b0, adiff_r};
        if (step_r == 3'd0) begin
          mul_b = {1'b0, adiff_r[CHUNK_W-1:0]};
        end else begin
          mul_b  = {{(MB_W-VAL_W+CHUNK_W){1'b0}}, adiff_r[VAL_W-1:CHUNK_W]};
          mul_sh = SH_24;
        end
      end
      S_AREA: begin
        mul_go = step_r < 3'(AREA_STEPS);
        case (step_r)
          3'd0: begin
            mul_a = {1'b0, sq_r[VAL_W-1:0]};
            mul_b = {1'b0, area_r[CHUNK_W-1:0]};
          end
          3'd1: begin
            mul_a  = {1'b0, sq_r[VAL_W-1:0]};
            mul_b  = {1'b0, area_r[COEF_W-1:CHUNK_W]};
            mul_sh = SH_24;
          end
          3'd2: begin
            mul_a  = {1'b0, sq_r[ESUM_W-1:VAL_W]};
            mul_b  = {1'b0, area_r[CHUNK_W-1:0]};
            mul_sh = SH_32;
          end
          default: begin
            mul_a  = {1'b0, sq_r[ESUM_W-1:VAL_W]};
            mul_b  = {1'b0, area_r[COEF_W-1:CHUNK_W]};
            mul_sh = SH_56;
          end
        endcase
      end
      default: begin
        mul_go = 1'b0;
      end
    endcase
  end

  always_comb begin
    prod_ext = ACC_W'(prod_r);
    case (sh_r)
      SH_0:    addend = prod_ext;
      SH_24:   addend = prod_ext <<< CHUNK_W;
      SH_32:   addend = prod_ext <<< VAL_W;
      default: addend = prod_ext <<< (VAL_W + CHUNK_W);
    endcase
    acc_nxt = pv_r ? acc_r + addend : acc_r;
  end

  // Rounded stencil sum, saturated to Q8.24, and its distance to the exact value.
  always_comb begin
    q = acc_r[ACC_W-1:FRAC_W];
    if (q > Q_W'(VALUE_MAX)) begin
      nv = VALUE_MAX;
    end else if (q < Q_W'(VALUE_MIN)) begin
      nv = VALUE_MIN;
    end else begin
      nv = q[VAL_W-1:0];
    end
    diff  = {nv[VAL_W-1], nv} - {op_e_r[VAL_W-1], op_e_r};
    adiff = diff[VAL_W] ? VAL_W'(-diff) : diff[VAL_W-1:0];
  end

  always_comb begin
    contrib  = acc_r[FRAC_W+ESUM_W-1:FRAC_W];
    esum_sum = {1'b0, esum_acc_r} + {1'b0, contrib};
    esum_new = esum_sum[ESUM_W] ? '1 : esum_sum[ESUM_W-1:0];
    max_new  = (adiff_r > max_acc_r) ? adiff_r : max_acc_r;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_LOAD) begin
      mem[c_r] <= {a_c, cur_r, fcur_r, ecur_r};
    end
    if (in_fire) begin
      rd_word_r <= mem[pos_col];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    sh_r   <= mul_sh;
    if (in_fire) begin
      cur_r  <= in_ch.old_value;
      fcur_r <= in_ch.forcing;
      ecur_r <= in_ch.exact;
      c_r    <= pos_col;
      r_r    <= pos_row;
    end
    case (state_r)
      S_LOAD: begin
        op_ew_r  <= MA_W'(a_c) + MA_W'(win_a2_r);
        op_ns_r  <= MA_W'(win_n_r) + MA_W'(win_s_r);
        op_f_r   <= -MA_W'(win_f_r);
        op_e_r   <= win_e_r;
        win_a2_r <= win_a1_r;
        win_a1_r <= a_c;
        win_n_r  <= t_c;
        win_s_r  <= cur_r;
        win_f_r  <= f_c;
        win_e_r  <= e_c;
        acc_r    <= ROUND_HALF;
      end
      S_ROUND: begin
        nv_r    <= nv;
        adiff_r <= adiff;
        acc_r   <= '0;
      end
      S_SQR: begin
        if (step_r == 3'(SQR_STEPS)) begin
          sq_r  <= acc_nxt[ESUM_W-1:0];
          acc_r <= ROUND_HALF;
        end else begin
          acc_r <= acc_nxt;
        end
      end
      S_STEN, S_AREA: begin
        acc_r <= acc_nxt;
      end
      default: begin
        acc_r <= acc_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      pv_r        <= 1'b0;
      col_cnt_r   <= '0;
      row_cnt_r   <= '0;
      max_acc_r   <= '0;
      esum_acc_r  <= '0;
      cfg_cols_r  <= COLUMNS_RESET;
      cfg_rows_r  <= ROWS_RESET;
      coef_ew_r   <= '0;
      coef_ns_r   <= '0;
      coef_f_r    <= '0;
      area_r      <= '0;
      out_valid_r <= 1'b0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_nv_r    <= '0;
      out_max_r   <= '0;
      out_esum_r  <= '0;
      out_last_r  <= 1'b0;
    end else begin
      pv_r <= mul_go;
      if (cfg_fire) begin
        unique case (cfg_ch.index)
          CFG_COLUMNS: cfg_cols_r <= cfg_ch.data[10:0];
          CFG_ROWS:    cfg_rows_r <= cfg_ch.data[12:0];
          CFG_COEF_EW: coef_ew_r  <= cfg_ch.data;
          CFG_COEF_NS: coef_ns_r  <= cfg_ch.data;
          CFG_COEF_F:  coef_f_r   <= cfg_ch.data;
          CFG_AREA:    area_r     <= cfg_ch.data;
          default: begin
            cfg_cols_r <= cfg_cols_r;
          end
        endcase
      end
      if (out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          col_cnt_r <= next_col;
          row_cnt_r <= next_row;
          step_r    <= '0;
          state_r   <= interior ? S_STEN : S_IDLE;
        end
        S_STEN: begin
          if (step_r == 3'(STEN_STEPS)) begin
            step_r  <= '0;
            state_r <= S_ROUND;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_ROUND: begin
          state_r <= S_SQR;
        end
        S_SQR: begin
          if (step_r == 3'(SQR_STEPS)) begin
            step_r  <= '0;
            state_r <= S_AREA;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_AREA: begin
          if (step_r == 3'(AREA_STEPS)) begin
            step_r  <= '0;
            state_r <= S_DONE;
          end else begin
            step_r <= step_r + 3'd1;
          end
        end
        S_DONE: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            out_row_r   <= 12'(32'(r_r) - 32'd1);
            out_col_r   <= 10'(32'(c_r) - 32'd1);
            out_nv_r    <= nv_r;
            out_max_r   <= max_new;
            out_esum_r  <= esum_new;
            out_last_r  <= is_last;
            max_acc_r   <= is_last ? '0 : max_new;
            esum_acc_r  <= is_last ? '0 : esum_new;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
